/* hw/rtl/ffpra_pkg.sv */
`default_nettype none
package ffpra_pkg;

    localparam int MAX_RUNS = 1024;
    localparam int IDX_W    = $clog2(MAX_RUNS);
    localparam int CNT_W    = $clog2(MAX_RUNS + 1);
    localparam int PAGE_W   = 20;
    localparam int PCNT_W   = 11;
    localparam int CAND_W   = PAGE_W + 1;
    localparam int ENTRY_W  = PAGE_W + PCNT_W;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        RS_IDX  = 2'd0,
        RS_DOWN = 2'd1,
        RS_UP   = 2'd2
    } t_rsel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_A_RD,
        S_A_EV,
        S_CHK,
        S_SU_RD,
        S_SU_WR,
        S_INS,
        S_F_RD,
        S_F_EV,
        S_SD_RD,
        S_SD_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    idx_inc;
        logic    idx_dec;
        logic    idx_ld_cnt;
        logic    cand_upd;
        logic    pos_ld;
        logic    wr_shift;
        logic    wr_new;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_ld;
        logic    res_addr;
        t_status res_status;
        t_rsel   rsel;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic unaligned;
        logic full;
        logic at_end;
        logic fit;
        logic match;
        logic ovf;
        logic at_pos;
        logic sd_end;
    } t_stat;

endpackage
`default_nettype wire

/* hw/rtl/ffpra_ctrl.sv */
`default_nettype none
module ffpra_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire                 i_stall,
    input  ffpra_pkg::t_stat    i_stat,
    output ffpra_pkg::t_cmd     o_cmd,
    output logic                o_stall,
    output logic                o_valid
);

    ffpra_pkg::t_state r_state;
    ffpra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ffpra_pkg::ST_OK;
        o_cmd.rsel       = ffpra_pkg::RS_IDX;
        o_stall = (r_state != ffpra_pkg::S_IDLE);
        o_valid = (r_state == ffpra_pkg::S_DONE);
        case (r_state)
            ffpra_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ffpra_pkg::S_DISP;
                end
            end
            ffpra_pkg::S_DISP: begin
                if (i_stat.is_free) begin
                    if (i_stat.unaligned) begin
                        o_cmd.res_ld = 1'b1;
                        o_cmd.res_status = ffpra_pkg::ST_NOT_FOUND;
                        n_state = ffpra_pkg::S_DONE;
                    end else begin
                        n_state = ffpra_pkg::S_F_RD;
                    end
                end else if (i_stat.full) begin
                    o_cmd.res_ld = 1'b1;
                    o_cmd.res_status = ffpra_pkg::ST_FULL;
                    n_state = ffpra_pkg::S_DONE;
                end else begin
                    n_state = ffpra_pkg::S_A_RD;
                end
            end
            ffpra_pkg::S_A_RD: begin
                if (i_stat.at_end) begin
                    o_cmd.pos_ld = 1'b1;
                    n_state = ffpra_pkg::S_CHK;
                end else begin
                    n_state = ffpra_pkg::S_A_EV;
                end
            end
            ffpra_pkg::S_A_EV: begin
                if (i_stat.fit) begin
                    o_cmd.pos_ld = 1'b1;
                    n_state = ffpra_pkg::S_CHK;
                end else begin
                    o_cmd.cand_upd = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state = ffpra_pkg::S_A_RD;
                end
            end
            ffpra_pkg::S_CHK: begin
                if (i_stat.ovf) begin
                    o_cmd.res_ld = 1'b1;
                    o_cmd.res_status = ffpra_pkg::ST_OVERFLOW;
                    n_state = ffpra_pkg::S_DONE;
                end else begin
                    o_cmd.idx_ld_cnt = 1'b1;
                    n_state = ffpra_pkg::S_SU_RD;
                end
            end
            ffpra_pkg::S_SU_RD: begin
                o_cmd.rsel = ffpra_pkg::RS_DOWN;
                if (i_stat.at_pos) begin
                    n_state = ffpra_pkg::S_INS;
                end else begin
                    n_state = ffpra_pkg::S_SU_WR;
                end
            end
            ffpra_pkg::S_SU_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_dec = 1'b1;
                n_state = ffpra_pkg::S_SU_RD;
            end
            ffpra_pkg::S_INS: begin
                o_cmd.wr_new = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.res_ld = 1'b1;
                o_cmd.res_addr = 1'b1;
                n_state = ffpra_pkg::S_DONE;
            end
            ffpra_pkg::S_F_RD: begin
                if (i_stat.at_end) begin
                    o_cmd.res_ld = 1'b1;
                    o_cmd.res_status = ffpra_pkg::ST_NOT_FOUND;
                    n_state = ffpra_pkg::S_DONE;
                end else begin
                    n_state = ffpra_pkg::S_F_EV;
                end
            end
            ffpra_pkg::S_F_EV: begin
                if (i_stat.match) begin
                    n_state = ffpra_pkg::S_SD_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ffpra_pkg::S_F_RD;
                end
            end
            ffpra_pkg::S_SD_RD: begin
                o_cmd.rsel = ffpra_pkg::RS_UP;
                if (i_stat.sd_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.res_ld = 1'b1;
                    n_state = ffpra_pkg::S_DONE;
                end else begin
                    n_state = ffpra_pkg::S_SD_WR;
                end
            end
            ffpra_pkg::S_SD_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = ffpra_pkg::S_SD_RD;
            end
            ffpra_pkg::S_DONE: begin
                if (!i_stall) begin
                    n_state = ffpra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffpra_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/ffpra_dp.sv */
`default_nettype none
module ffpra_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ffpra_pkg::t_cmd     i_cmd,
    input  wire [31:0]          i_pool_base,
    input  wire                 i_req_type,
    input  wire [10:0]          i_page_count,
    input  wire [31:0]          i_free_base,
    output ffpra_pkg::t_stat    o_stat,
    output logic [31:0]         o_run_address,
    output logic [1:0]          o_status
);

    localparam int IW = ffpra_pkg::IDX_W;
    localparam int CW = ffpra_pkg::CNT_W;
    localparam int AW = ffpra_pkg::CAND_W;

    logic [ffpra_pkg::ENTRY_W-1:0] r_mem [ffpra_pkg::MAX_RUNS];
    logic [ffpra_pkg::ENTRY_W-1:0] r_rd_data;

    logic                r_is_free;
    logic [10:0]         r_cnt_req;
    logic [31:0]         r_free_base;
    logic [AW-1:0]       r_cand;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_pos;
    logic [CW-1:0]       r_run_count;
    logic [31:0]         r_run_address;
    logic [1:0]          r_status;

    logic [CW-1:0]       rd_addr;
    logic [CW-1:0]       wr_addr;
    logic [AW-1:0]       rb;
    logic [AW-1:0]       re;
    logic [AW-1:0]       gap;
    logic [CW:0]         idx_next;
    logic [AW:0]         end_sum;

    always_comb begin
        case (i_cmd.rsel)
            ffpra_pkg::RS_DOWN: rd_addr = r_idx - CW'(1);
            ffpra_pkg::RS_UP:   rd_addr = r_idx + CW'(1);
            default:            rd_addr = r_idx;
        endcase
        wr_addr = i_cmd.wr_new ? r_pos : r_idx;
    end

    // Run table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            r_mem[wr_addr[IW-1:0]] <= {r_cand[ffpra_pkg::PAGE_W-1:0], r_cnt_req};
        end else if (i_cmd.wr_shift) begin
            r_mem[wr_addr[IW-1:0]] <= r_rd_data;
        end
        r_rd_data <= r_mem[rd_addr[IW-1:0]];
    end

    assign rb       = {1'b0, r_rd_data[ffpra_pkg::ENTRY_W-1:ffpra_pkg::PCNT_W]};
    assign re       = rb + AW'(r_rd_data[ffpra_pkg::PCNT_W-1:0]);
    assign gap      = rb - r_cand;
    assign idx_next = {1'b0, r_idx} + (CW+1)'(1);
    assign end_sum  = {1'b0, r_cand} + (AW+1)'(r_cnt_req);

    always_comb begin
        o_stat.is_free   = r_is_free;
        o_stat.unaligned = (r_free_base[11:0] != 12'd0);
        o_stat.full      = (r_run_count >= CW'(ffpra_pkg::MAX_RUNS));
        o_stat.at_end    = (r_idx == r_run_count);
        o_stat.fit       = (rb >= r_cand) && (gap >= AW'(r_cnt_req));
        o_stat.match     = (r_rd_data[ffpra_pkg::ENTRY_W-1:ffpra_pkg::PCNT_W]
                            == r_free_base[31:12]);
        o_stat.ovf       = (end_sum > (AW+1)'(1 << ffpra_pkg::PAGE_W));
        o_stat.at_pos    = (r_idx == r_pos);
        o_stat.sd_end    = (idx_next >= {1'b0, r_run_count});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_free   <= (i_req_type == ffpra_pkg::REQ_FREE);
            r_cnt_req   <= (i_page_count == 11'd0) ? 11'd1 : i_page_count;
            r_free_base <= i_free_base;
            r_cand      <= {1'b0, i_pool_base[31:12]};
        end else if (i_cmd.cand_upd && (re > r_cand)) begin
            r_cand <= re;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_ld_cnt) begin
            r_idx <= r_run_count;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - CW'(1);
        end
        if (i_cmd.pos_ld) begin
            r_pos <= r_idx;
        end
        if (i_cmd.res_ld) begin
            r_status      <= i_cmd.res_status;
            r_run_address <= i_cmd.res_addr
                ? {r_cand[ffpra_pkg::PAGE_W-1:0], 12'd0} : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_run_count <= r_run_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_run_count <= r_run_count - CW'(1);
        end
    end

    assign o_run_address = r_run_address;
    assign o_status      = r_status;

endmodule
`default_nettype wire

/* hw/rtl/first_fit_page_run_allocator_top.sv */
`default_nettype none
// First-fit allocator of runs of 4 KiB pages. The block keeps an address-ordered
// table of allocated runs (up to 1024) above the pool base register. Each request
// is one transaction on the input channel and yields exactly one result
// transaction. Requests are handled one at a time: the input stall is high from
// acceptance until the result has been taken, and drops in the cycle after that.
// An allocate walks the table, reading and then evaluating each entry, until a
// gap fits, then shifts the entries above the insertion point up, reading and
// then writing each one. A free walks to the matching run and shifts the rest
// down in the same way. An allocate into a full table or a free of an unaligned
// base is answered from the dispatch state without a walk. The pace is set by
// the single read and single write port of the run table memory. The pool base
// register sits at byte address 0 of the APB port and should only be written
// while no transaction is in flight.
module first_fit_page_run_allocator_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel.
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_req_type,
    input  wire [10:0]  i_page_count,
    input  wire [31:0]  i_free_base,
    // Result channel.
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_run_address,
    output logic [1:0]  o_status
);

    ffpra_pkg::t_cmd  cmd;
    ffpra_pkg::t_stat stat;
    logic [31:0]      r_pool_base;

    // The base register is written on the access cycle of an APB write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= 32'd0;
        end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
            r_pool_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? r_pool_base : 32'd0;

    ffpra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    ffpra_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pool_base   (r_pool_base),
        .i_req_type    (i_req_type),
        .i_page_count  (i_page_count),
        .i_free_base   (i_free_base),
        .o_stat        (stat),
        .o_run_address (o_run_address),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
`default_nettype none

// Testbench for the first-fit page-run allocator.
module tb;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 5;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;

    // Request transaction as queued for the driver.
    typedef struct packed {
        ffpra_pkg::t_req kind;
        logic [10:0]     pages;
        logic [31:0]     base;
    } t_request;

    // Result transaction as expected from the block.
    typedef struct packed {
        logic [31:0]        addr;
        ffpra_pkg::t_status status;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [10:0] i_page_count;
    logic [31:0] i_free_base;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_run_address;
    logic [1:0]  o_status;

    first_fit_page_run_allocator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_page_count  (i_page_count),
        .i_free_base   (i_free_base),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_run_address (o_run_address),
        .o_status      (o_status)
    );

    // Shadow of the allocator's state: the ordered table of runs and the pool base.
    logic [19:0] run_page [$];
    logic [10:0] run_pages [$];
    logic [31:0] pool_base;

    t_request pending_requests [$];
    t_outcome awaited_results [$];
    logic [31:0] live_bases [$];

    int  error_count;
    int  idle_cycles;
    bit  sender_hold;
    int  hold_off_cycles;
    bit  hold_off_request;
    bit  in_taken;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Works out the outcome of one request and updates the shadow table.
    function automatic t_outcome allocate_or_free(input t_request req);
        t_outcome res;
        logic [31:0] cand;
        logic [31:0] want;
        logic [31:0] rb;
        logic [31:0] re;
        int pos;
        logic [19:0] page;
        res.addr   = '0;
        res.status = ffpra_pkg::ST_OK;
        if (req.kind == ffpra_pkg::REQ_ALLOC) begin
            want = {21'd0, req.pages};
            if (want == 0) want = 1;
            if (run_page.size() >= ffpra_pkg::MAX_RUNS) begin
                res.status = ffpra_pkg::ST_FULL;
                return res;
            end
            cand = {12'd0, pool_base[31:12]};
            pos  = run_page.size();
            for (int i = 0; i < run_page.size(); i++) begin
                rb = {12'd0, run_page[i]};
                re = rb + {21'd0, run_pages[i]};
                if (rb >= cand && rb - cand >= want) begin
                    pos = i;
                    break;
                end
                if (re > cand) cand = re;
            end
            if (cand + want > 32'h0010_0000) begin
                res.status = ffpra_pkg::ST_OVERFLOW;
                return res;
            end
            run_page.insert(pos, cand[19:0]);
            run_pages.insert(pos, want[10:0]);
            res.addr = {cand[19:0], 12'd0};
        end else begin
            page = req.base[31:12];
            if (req.base[11:0] == 12'd0) begin
                for (int i = 0; i < run_page.size(); i++) begin
                    if (run_page[i] == page) begin
                        run_page.delete(i);
                        run_pages.delete(i);
                        return res;
                    end
                end
            end
            res.status = ffpra_pkg::ST_NOT_FOUND;
        end
        return res;
    endfunction

    // Driver: bursts of requests with random gaps, changing at the falling edge.
    int burst_left;
    int gap_left;
    initial begin
        burst_left = 0;
        gap_left   = 0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // Payload held until the transaction is accepted.
        end else begin
            if (in_taken) begin
                pending_requests.pop_front();
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_requests.size() != 0 && !sender_hold) begin
                i_valid      <= 1'b1;
                i_req_type   <= pending_requests[0].kind;
                i_page_count <= pending_requests[0].pages;
                i_free_base  <= pending_requests[0].base;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // On acceptance at the rising edge the prediction is made and queued.
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            awaited_results.push_back(allocate_or_free(
                '{kind: ffpra_pkg::t_req'(i_req_type), pages: i_page_count,
                  base: i_free_base}));
        end
    end

    // Receiver stall pattern, with an occasional long hold-off on request.
    int stall_mode;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_mode <= 0;
        end else if (hold_off_cycles > 0) begin
            i_stall         <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (hold_off_request) begin
            hold_off_request <= 1'b0;
            hold_off_cycles  <= 300;
            i_stall          <= 1'b1;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // Monitor: each result transaction is compared with the oldest expectation.
    t_outcome want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result addr=%h status=%0d",
                         $time, o_run_address, o_status);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_run_address !== want.addr) begin
                    $display("%0t: run_address expected %h actual %h",
                             $time, want.addr, o_run_address);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_pool_base(input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_base = value;
    endtask

    // Waits until every queued request is taken and every result has come back.
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_alloc(input logic [10:0] pages);
        pending_requests.push_back('{kind: ffpra_pkg::REQ_ALLOC, pages: pages, base: '0});
    endtask

    task automatic queue_free(input logic [31:0] base);
        pending_requests.push_back('{kind: ffpra_pkg::REQ_FREE, pages: 11'($urandom),
                                     base: base});
    endtask

    // A random request, weighted towards small runs and frees of plausible bases.
    task automatic queue_random(input logic [31:0] base_now);
        logic [31:0] b;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 19) == 0) queue_alloc(11'($urandom));
            else queue_alloc(11'($urandom_range(0, 24)));
        end else if (pick < 92) begin
            // Likely a live run: base plus a page multiple near the start.
            b = base_now + {20'($urandom_range(0, 400)), 12'd0};
            queue_free(b);
        end else begin
            queue_free($urandom);
        end
    endtask

    int random_items;
    logic [31:0] bases [4];

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_valid      = 1'b0;
        i_req_type   = 1'b0;
        i_page_count = '0;
        i_free_base  = '0;
        i_stall      = 1'b0;
        pool_base    = '0;
        error_count  = 0;
        idle_cycles  = 0;
        sender_hold  = 1'b0;
        in_taken     = 1'b0;
        hold_off_cycles  = 0;
        hold_off_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at reset base zero: zero count, extremes, frees of all kinds.
        queue_alloc(11'd0);
        queue_alloc(11'd1);
        queue_alloc(11'd1024);
        queue_alloc(11'd2047);
        queue_free(32'h0000_0000);
        queue_alloc(11'd1);
        queue_free(32'h0000_1001);
        queue_free(32'hFFFF_F000);
        queue_free(32'h0000_1000);
        queue_alloc(11'd2);
        queue_alloc(11'd1);
        wait_quiet();

        // Base near the top of the space: overflow and a run ending exactly at 4 GiB.
        write_pool_base(32'hFFFF_FFFF);
        queue_alloc(11'd2);
        queue_alloc(11'd1);
        queue_alloc(11'd1);
        queue_free(32'hFFFF_F000);
        wait_quiet();

        // Base moved down below old runs, then the highest useful page base.
        write_pool_base(32'h0000_0000);
        queue_alloc(11'd3);
        queue_alloc(11'd2047);
        wait_quiet();
        write_pool_base(32'hFFFF_E000);
        queue_alloc(11'd1);
        queue_alloc(11'd1);
        wait_quiet();

        // Random phases across several pool bases, with a long receiver hold-off
        // in the first and a sender pause until the block drains in the second.
        bases[0] = 32'h0000_0000;
        bases[1] = 32'h8000_0ABC;
        bases[2] = 32'hFFF0_0000;
        bases[3] = $urandom;
        random_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_pool_base(bases[ph]);
            if (ph == 0) hold_off_request = 1'b1;
            for (int n = 0; n < 140; n++) begin
                queue_random({bases[ph][31:12], 12'd0});
                random_items++;
                if (ph == 1 && n == 70) begin
                    sender_hold = 1'b1;
                    while (i_valid || awaited_results.size() != 0 || o_stall)
                        @(posedge i_clk);
                    sender_hold = 1'b0;
                end
            end
            wait_quiet();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
